// ===== src/yrfp_pkg.sv =====
package yrfp_pkg;

    // Item opcodes
    localparam logic [1:0] OP_HEADING = 2'd0;
    localparam logic [1:0] OP_RATE    = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PREDICT_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_ENABLE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_NEGATE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_TIMEOUT     = 3'd4;
    localparam int unsigned CFG_DATA_W = 23;

    // Field widths
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned DT_W      = 21;
    localparam int unsigned HEADING_W = 16;
    localparam int unsigned RATE_W    = 24;
    localparam int unsigned LIMIT_W   = 23;
    localparam int unsigned FRAC_SH   = 20;

    // Register reset values
    localparam logic [DT_W-1:0]    RST_MAX_PREDICT_TIME = 21'd157286;
    localparam logic [LIMIT_W-1:0] RST_RATE_LIMIT       = 23'd125167;
    localparam logic [DT_W-1:0]    RST_RATE_TIMEOUT     = 21'd52429;

    // Floor on the freshness timeout (about 1 ms)
    localparam logic [DT_W-1:0] MIN_TIMEOUT = 21'd1049;

    localparam logic signed [RATE_W-1:0] RATE_MAX = 24'sh7FFFFF;

    typedef struct packed {
        logic [1:0]                  opcode;
        logic [TIME_W-1:0]           now_time;
        logic [TIME_W-1:0]           odom_stamp;
        logic signed [HEADING_W-1:0] odom_heading;
        logic signed [RATE_W-1:0]    rate_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [HEADING_W-1:0] fused_heading;
        logic [DT_W-1:0]             predict_time;
        logic                        rate_used;
    } t_out_item;

endpackage

// ===== src/yrfp_stream_if.sv =====
interface yrfp_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/yaw_rate_forward_prediction_core.sv =====
// Heading dead-reckoning predictor.
// Input channel i_in carries items of three kinds: an odometry heading with
// its stamp, a gyro yaw rate sample, and an output tick. Only a tick that
// arrives after the first heading produces a result item on o_out: the
// stored heading advanced by rate * dt, dt being the clamped time since the
// odometry stamp, plus dt itself and a flag telling whether the rate counted.
// Two register stages: operand prep with the age/limit compares, then the
// 24x22 multiply and heading add, registered onto o_out. Throughput is
// one item per cycle while o_out is not stalled; heading and rate items
// update state at their accept edge and the next item sees them at once.
// When o_out is stalled the result register holds; the operand stage still
// accepts one more tick, and non-result items keep flowing while that stage
// is free or moving. Ready then drops until the receiver takes the result.
// Reset (synchronous, active low) restores the register defaults, forgets
// heading and rate, and empties both stages. Configuration is written over
// i_cfg_we/i_cfg_index/i_cfg_data; the user must write it only while no
// tick is in flight, and the block itself does not enforce this.
module yaw_rate_forward_prediction_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [yrfp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [yrfp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    yrfp_stream_if.sink                         i_in,
    yrfp_stream_if.source                       o_out
);

    // Configuration registers
    logic [yrfp_pkg::DT_W-1:0]    r_max_predict_time;
    logic                         r_rate_enable;
    logic                         r_rate_negate;
    logic [yrfp_pkg::LIMIT_W-1:0] r_rate_limit;
    logic [yrfp_pkg::DT_W-1:0]    r_rate_timeout;

    // Sensor state
    logic                                   r_heading_seen;
    logic signed [yrfp_pkg::HEADING_W-1:0]  r_last_heading;
    logic [yrfp_pkg::TIME_W-1:0]            r_heading_stamp;
    logic                                   r_rate_seen;
    logic signed [yrfp_pkg::RATE_W-1:0]     r_last_rate;
    logic [yrfp_pkg::TIME_W-1:0]            r_rate_stamp;

    // Operand stage
    logic                                   r_s1_valid;
    logic signed [yrfp_pkg::HEADING_W-1:0]  r_s1_heading;
    logic signed [yrfp_pkg::RATE_W-1:0]     r_s1_rate;
    logic [yrfp_pkg::DT_W-1:0]              r_s1_dt;
    logic                                   r_s1_used;

    // Result stage
    logic                                   r_s2_valid;
    yrfp_pkg::t_out_item                    r_s2_item;

    yrfp_pkg::t_in_item                     w_in;
    logic                                   w_s2_load;
    logic                                   w_in_ready;
    logic                                   w_in_acc;
    logic                                   w_tick;

    assign w_in       = i_in.data;
    assign w_s2_load  = !r_s2_valid || o_out.ready;
    assign w_in_ready = !r_s1_valid || w_s2_load;
    assign w_in_acc   = i_in.valid && w_in_ready;
    assign w_tick     = w_in_acc && (w_in.opcode == yrfp_pkg::OP_TICK) && r_heading_seen;

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = r_s2_valid;
    assign o_out.data  = r_s2_item;

    // Incoming rate: optional negate, then saturate the one overflow case
    logic signed [yrfp_pkg::RATE_W:0]   w_rate_ext;
    logic signed [yrfp_pkg::RATE_W:0]   w_rate_neg;
    logic signed [yrfp_pkg::RATE_W-1:0] n_last_rate;

    always_comb begin
        w_rate_ext = {w_in.rate_sample[yrfp_pkg::RATE_W-1], w_in.rate_sample};
        w_rate_neg = r_rate_negate ? -w_rate_ext : w_rate_ext;
        if (w_rate_neg[yrfp_pkg::RATE_W] != w_rate_neg[yrfp_pkg::RATE_W-1]) begin
            n_last_rate = yrfp_pkg::RATE_MAX;
        end else begin
            n_last_rate = w_rate_neg[yrfp_pkg::RATE_W-1:0];
        end
    end

    // Rate validity: enabled, seen, fresh and within limit
    logic [yrfp_pkg::TIME_W-1:0]  w_age;
    logic [yrfp_pkg::DT_W-1:0]    w_timeout;
    logic [yrfp_pkg::RATE_W-1:0]  w_mag;
    logic                         w_fresh;
    logic                         w_in_range;
    logic                         n_s1_used;

    always_comb begin
        w_age     = w_in.now_time - r_rate_stamp;
        w_timeout = (r_rate_timeout < yrfp_pkg::MIN_TIMEOUT) ? yrfp_pkg::MIN_TIMEOUT
                                                              : r_rate_timeout;
        // negative age counts as fresh
        w_fresh   = w_age[yrfp_pkg::TIME_W-1] ||
                    (w_age[yrfp_pkg::TIME_W-2:0] <=
                     {{(yrfp_pkg::TIME_W-1-yrfp_pkg::DT_W){1'b0}}, w_timeout});
        w_mag     = r_last_rate[yrfp_pkg::RATE_W-1] ? (-r_last_rate) : r_last_rate;
        w_in_range = (r_rate_limit == '0) || (w_mag <= {1'b0, r_rate_limit});
        n_s1_used = r_rate_enable && r_rate_seen && w_fresh && w_in_range;
    end

    // Prediction time, clamped to 0..max
    logic [yrfp_pkg::TIME_W-1:0] w_elapsed;
    logic [yrfp_pkg::DT_W-1:0]   n_s1_dt;

    always_comb begin
        w_elapsed = w_in.now_time - r_heading_stamp;
        if (w_elapsed[yrfp_pkg::TIME_W-1]) begin
            n_s1_dt = '0;
        end else if (w_elapsed > {{(yrfp_pkg::TIME_W-yrfp_pkg::DT_W){1'b0}},
                                  r_max_predict_time}) begin
            n_s1_dt = r_max_predict_time;
        end else begin
            n_s1_dt = w_elapsed[yrfp_pkg::DT_W-1:0];
        end
    end

    // Multiply and wrap-add; arithmetic shift gives the floor
    logic signed [yrfp_pkg::RATE_W+yrfp_pkg::DT_W:0] w_prod;
    yrfp_pkg::t_out_item                             n_s2_item;

    always_comb begin
        w_prod = r_s1_rate * $signed({1'b0, r_s1_dt});
        n_s2_item.fused_heading = r_s1_heading +
            w_prod[yrfp_pkg::FRAC_SH+yrfp_pkg::HEADING_W-1:yrfp_pkg::FRAC_SH];
        n_s2_item.predict_time  = r_s1_dt;
        n_s2_item.rate_used     = r_s1_used;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_predict_time <= yrfp_pkg::RST_MAX_PREDICT_TIME;
            r_rate_enable      <= 1'b1;
            r_rate_negate      <= 1'b0;
            r_rate_limit       <= yrfp_pkg::RST_RATE_LIMIT;
            r_rate_timeout     <= yrfp_pkg::RST_RATE_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                yrfp_pkg::REG_MAX_PREDICT_TIME: begin
                    r_max_predict_time <= i_cfg_data[yrfp_pkg::DT_W-1:0];
                end
                yrfp_pkg::REG_RATE_ENABLE: begin
                    r_rate_enable <= i_cfg_data[0];
                end
                yrfp_pkg::REG_RATE_NEGATE: begin
                    r_rate_negate <= i_cfg_data[0];
                end
                yrfp_pkg::REG_RATE_LIMIT: begin
                    r_rate_limit <= i_cfg_data[yrfp_pkg::LIMIT_W-1:0];
                end
                yrfp_pkg::REG_RATE_TIMEOUT: begin
                    r_rate_timeout <= i_cfg_data[yrfp_pkg::DT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Sensor state updates at the accept edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading_seen  <= 1'b0;
            r_last_heading  <= '0;
            r_heading_stamp <= '0;
            r_rate_seen     <= 1'b0;
            r_last_rate     <= '0;
            r_rate_stamp    <= '0;
        end else if (w_in_acc) begin
            if (w_in.opcode == yrfp_pkg::OP_HEADING) begin
                r_heading_seen  <= 1'b1;
                r_last_heading  <= w_in.odom_heading;
                r_heading_stamp <= w_in.odom_stamp;
            end else if (w_in.opcode == yrfp_pkg::OP_RATE) begin
                r_rate_seen  <= 1'b1;
                r_last_rate  <= n_last_rate;
                r_rate_stamp <= w_in.now_time;
            end
        end
    end

    // Pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_in_ready) begin
                r_s1_valid <= w_tick;
            end
            if (w_s2_load) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_s1_heading <= r_last_heading;
            r_s1_rate    <= n_s1_used ? r_last_rate : '0;
            r_s1_dt      <= n_s1_dt;
            r_s1_used    <= n_s1_used;
        end
        if (w_s2_load && r_s1_valid) begin
            r_s2_item <= n_s2_item;
        end
    end

    // Checks
    a_unused_rate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !r_s1_used |-> r_s1_rate == '0)
        else $error("unused rate reached the multiplier");

    a_dt_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> r_s1_dt <= r_max_predict_time)
        else $error("prediction time above clamp");

    a_plain_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s2_load && r_s1_valid && !r_s1_used
        |=> o_out.data.fused_heading == $past(r_s1_heading))
        else $error("heading moved without a valid rate");

    a_result_needs_heading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> r_heading_seen)
        else $error("result before any heading");

    a_used_needs_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_used |-> r_rate_seen && r_rate_enable)
        else $error("rate used without a stored sample");

endmodule
